// ===== rtl/mlft_pkg.sv =====
package mlft_pkg;

   localparam int ENTRIES    = 16;
   localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W      = $clog2(ENTRIES + 1);
   localparam int MAC_W      = 48;
   localparam int PORT_W     = 3;
   localparam int AGE_W      = 9;
   localparam int SPAN_W     = 5;
   localparam int MASK_W     = 8;
   localparam int CMD_W      = 2;
   localparam int STATUS_W   = 2;
   localparam int CSR_DATA_W = 9;
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 16;

   localparam logic [MASK_W-1:0] FLOOD_MASK      = 8'hFF;
   localparam logic [AGE_W-1:0]  AGE_LIMIT_RESET = AGE_W'(60 * 5);
   localparam logic [SPAN_W-1:0] SPAN_RESET      = SPAN_W'(ENTRIES);

   typedef enum logic [CMD_W-1:0] {
      CMD_LEARN  = 2'd0,
      CMD_LOOKUP = 2'd1,
      CMD_TICK   = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      LS_REFRESHED = 2'd0,
      LS_NEW_ENTRY = 2'd1,
      LS_FULL      = 2'd2,
      LS_NOT_LEARN = 2'd3
   } learn_status_type;

   typedef enum logic [0:0] {
      CSR_ENTRIES_IN_USE = 1'b0,
      CSR_AGE_LIMIT      = 1'b1
   } csr_idx_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;
      logic step;
      logic rec_free;
      logic set_hit;
      logic wr_refresh;
      logic wr_age;
      logic wr_new;
      logic load_rsp;
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             span_zero;
      logic             last;
      logic             entry_valid;
      logic             entry_match;
      logic             free_found;
      logic             rsp_busy;
   } dp_stat_type;

endpackage

// ===== rtl/mlft_ctrl.sv =====
module mlft_ctrl
   import mlft_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  dp_stat_type  stat,
   output ctrl_cmd_type cmd
);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SCAN   = 4'b0010,
      S_WRITE  = 4'b0100,
      S_FINISH = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = S_SCAN;
            end
         end
         S_SCAN: begin
            if (stat.span_zero) begin
               state_in = S_FINISH;
            end else begin
               case (stat.cmd)
                  CMD_LEARN: begin
                     if (stat.entry_match) begin
                        cmd.set_hit    = 1'b1;
                        cmd.wr_refresh = 1'b1;
                        state_in       = S_FINISH;
                     end else begin
                        // remember the lowest free slot
                        if (!stat.entry_valid && !stat.free_found) begin
                           cmd.rec_free = 1'b1;
                        end
                        if (stat.last) begin
                           state_in = (stat.free_found || !stat.entry_valid) ?
                                      S_WRITE : S_FINISH;
                        end else begin
                           cmd.step = 1'b1;
                        end
                     end
                  end
                  CMD_LOOKUP: begin
                     if (stat.entry_match) begin
                        cmd.set_hit = 1'b1;
                        state_in    = S_FINISH;
                     end else if (stat.last) begin
                        state_in = S_FINISH;
                     end else begin
                        cmd.step = 1'b1;
                     end
                  end
                  CMD_TICK: begin
                     cmd.wr_age = stat.entry_valid;
                     if (stat.last) begin
                        state_in = S_FINISH;
                     end else begin
                        cmd.step = 1'b1;
                     end
                  end
                  default: begin
                     state_in = S_FINISH;
                  end
               endcase
            end
         end
         S_WRITE: begin
            cmd.wr_new = 1'b1;
            state_in   = S_FINISH;
         end
         S_FINISH: begin
            if (!stat.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/mlft_dp.sv =====
module mlft_dp
   import mlft_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  ctrl_cmd_type            cmd,
   output dp_stat_type             stat,
   input  logic [CMD_W-1:0]        req_cmd,
   input  logic [MAC_W-1:0]        req_mac,
   input  logic [PORT_W-1:0]       req_port,
   input  logic                    csr_we,
   input  logic [0:0]              csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data,
   input  logic                    rsp_tready,
   output logic                    rsp_tvalid,
   output logic [MASK_W-1:0]       rsp_port_mask,
   output logic                    rsp_hit,
   output logic [STATUS_W-1:0]     rsp_learn_status
);

   // table
   logic                used_ff [ENTRIES];
   logic [MAC_W-1:0]    mac_ff  [ENTRIES];
   logic [PORT_W-1:0]   port_ff [ENTRIES];
   logic [AGE_W-1:0]    age_ff  [ENTRIES];

   // configuration
   logic [SPAN_W-1:0]   span_cfg_ff;
   logic [AGE_W-1:0]    age_limit_ff;

   // current item
   logic [CMD_W-1:0]    item_cmd_ff;
   logic [MAC_W-1:0]    item_mac_ff;
   logic [PORT_W-1:0]   item_port_ff;
   logic [IDX_W-1:0]    idx_ff;
   logic [IDX_W-1:0]    free_idx_ff;
   logic                free_found_ff;
   logic                hit_ff;
   logic                new_ff;
   logic [PORT_W-1:0]   hit_port_ff;

   // result register
   logic                rsp_valid_ff;
   logic [MASK_W-1:0]   rsp_mask_ff;
   logic                rsp_hit_ff;
   logic [STATUS_W-1:0] rsp_status_ff;

   logic [CNT_W-1:0]    span;
   logic                e_used;
   logic [MAC_W-1:0]    e_mac;
   logic [PORT_W-1:0]   e_port;
   logic [AGE_W-1:0]    e_age;
   logic [AGE_W-1:0]    age_dec;
   logic                e_valid;
   logic [MASK_W-1:0]   mask_in;
   logic [STATUS_W-1:0] status_in;

   always_comb begin
      if (int'(span_cfg_ff) > ENTRIES) begin
         span = CNT_W'(ENTRIES);
      end else begin
         span = CNT_W'(span_cfg_ff);
      end
   end

   assign e_used  = used_ff[idx_ff];
   assign e_mac   = mac_ff[idx_ff];
   assign e_port  = port_ff[idx_ff];
   assign e_age   = age_ff[idx_ff];
   assign age_dec = e_age - AGE_W'(1);
   assign e_valid = e_used && (e_age != '0);

   assign stat.cmd         = item_cmd_ff;
   assign stat.span_zero   = (span == '0);
   assign stat.last        = ((CNT_W'(idx_ff) + CNT_W'(1)) == span);
   assign stat.entry_valid = e_valid;
   assign stat.entry_match = e_valid && (e_mac == item_mac_ff);
   assign stat.free_found  = free_found_ff;
   assign stat.rsp_busy    = rsp_valid_ff && !rsp_tready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         span_cfg_ff  <= SPAN_RESET;
         age_limit_ff <= AGE_LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ENTRIES_IN_USE: span_cfg_ff  <= csr_data[SPAN_W-1:0];
            CSR_AGE_LIMIT:      age_limit_ff <= csr_data[AGE_W-1:0];
            default: ;
         endcase
      end
   end

   // valid bits: reset clears the whole table at once
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < ENTRIES; k++) begin
            used_ff[k] <= 1'b0;
         end
      end else if (cmd.wr_new) begin
         used_ff[free_idx_ff] <= 1'b1;
      end else if (cmd.wr_age && (age_dec == '0)) begin
         used_ff[idx_ff] <= 1'b0;
      end
   end

   // entry payload
   always_ff @(posedge clock) begin
      if (cmd.wr_new) begin
         mac_ff[free_idx_ff]  <= item_mac_ff;
         port_ff[free_idx_ff] <= item_port_ff;
         age_ff[free_idx_ff]  <= age_limit_ff;
      end else if (cmd.wr_refresh) begin
         port_ff[idx_ff] <= item_port_ff;
         age_ff[idx_ff]  <= age_limit_ff;
      end else if (cmd.wr_age) begin
         age_ff[idx_ff] <= age_dec;
      end
   end

   // scan bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff        <= '0;
         free_found_ff <= 1'b0;
         hit_ff        <= 1'b0;
         new_ff        <= 1'b0;
         item_cmd_ff   <= CMD_TICK;
      end else if (cmd.accept) begin
         idx_ff        <= '0;
         free_found_ff <= 1'b0;
         hit_ff        <= 1'b0;
         new_ff        <= 1'b0;
         item_cmd_ff   <= req_cmd;
      end else begin
         if (cmd.step) begin
            idx_ff <= idx_ff + IDX_W'(1);
         end
         if (cmd.rec_free) begin
            free_found_ff <= 1'b1;
         end
         if (cmd.set_hit) begin
            hit_ff <= 1'b1;
         end
         if (cmd.wr_new) begin
            new_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         item_mac_ff  <= req_mac;
         item_port_ff <= req_port;
      end
      if (cmd.rec_free) begin
         free_idx_ff <= idx_ff;
      end
      if (cmd.set_hit) begin
         hit_port_ff <= e_port;
      end
   end

   // result formatting
   always_comb begin
      mask_in   = '0;
      status_in = LS_NOT_LEARN;
      case (item_cmd_ff)
         CMD_LEARN: begin
            if (hit_ff) begin
               status_in = LS_REFRESHED;
            end else if (new_ff) begin
               status_in = LS_NEW_ENTRY;
            end else begin
               status_in = LS_FULL;
            end
         end
         CMD_LOOKUP: begin
            mask_in = hit_ff ? (MASK_W'(1) << hit_port_ff) : FLOOD_MASK;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_mask_ff   <= mask_in;
         rsp_hit_ff    <= hit_ff;
         rsp_status_ff <= status_in;
      end
   end

   assign rsp_tvalid       = rsp_valid_ff;
   assign rsp_port_mask    = rsp_mask_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_learn_status = rsp_status_ff;

endmodule

// ===== rtl/mac_learning_forwarding_table.sv =====
// Flow: an accepted request word walks the entries, one per cycle over the span set by
//   entries_in_use; a match (learn or lookup), a span of zero or the unused command ends
//   the walk early. A learn that allocates then writes the new entry. The result loads
//   once any pending response is taken, and only then is the next word accepted.
// Reset (synchronous, active high): all entries free, entries_in_use = 16,
//   age_limit = 300, no response pending. No clearing pass is needed.
module mac_learning_forwarding_table
   import mlft_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   // request stream
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [REQ_DATA_W-1:0]   req_tdata,   // [47:0] mac, [50:48] port, rest zero
   input  logic [CMD_W-1:0]        req_tuser,   // [1:0] cmd
   // response stream
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RSP_DATA_W-1:0]   rsp_tdata,   // [7:0] port_mask, [8] hit,
                                                // [10:9] learn_status, rest zero
   // register write channel
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [0:0]              csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data
);

   ctrl_cmd_type        cmd;
   dp_stat_type         stat;
   logic [MASK_W-1:0]   rsp_port_mask;
   logic                rsp_hit;
   logic [STATUS_W-1:0] rsp_learn_status;

   // registers are always writable; software writes only while the table is idle (the block does not enforce it)
   assign csr_ready = 1'b1;

   // sequencer: walks the entries one per cycle and issues table writes
   mlft_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // table storage, compare, config registers and response register
   mlft_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_cmd          (req_tuser),
      .req_mac          (req_tdata[MAC_W-1:0]),
      .req_port         (req_tdata[MAC_W +: PORT_W]),
      .csr_we           (csr_valid),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .rsp_tready       (rsp_tready),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_port_mask    (rsp_port_mask),
      .rsp_hit          (rsp_hit),
      .rsp_learn_status (rsp_learn_status)
   );

   // pack the response word, padding to whole bytes
   assign rsp_tdata = {(RSP_DATA_W - MASK_W - 1 - STATUS_W)'(0),
                       rsp_learn_status, rsp_hit, rsp_port_mask};

endmodule

// ===== rtl/mlft_checker.sv =====
module mlft_checker
   import mlft_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic [CMD_W-1:0]      req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  csr_valid,
   input logic                  csr_ready,
   input logic [0:0]            csr_index,
   input logic [CSR_DATA_W-1:0] csr_data
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response word changed while stalled");

   // one word in flight: the input closes right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request taken while one is in flight");

   // learn results carry no mask and hit only when refreshed
   a_learn_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[10:9] != LS_NOT_LEARN) |->
         (rsp_tdata[7:0] == '0) && (rsp_tdata[8] == (rsp_tdata[10:9] == LS_REFRESHED)))
      else $error("learn response fields inconsistent");

   // a lookup hit forwards to exactly one port
   a_hit_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[10:9] == LS_NOT_LEARN) && rsp_tdata[8] |->
         $onehot(rsp_tdata[7:0]))
      else $error("lookup hit mask is not one-hot");

endmodule

bind mac_learning_forwarding_table mlft_checker u_mlft_checker (.*);
